// File: hdl/dws_pkg.sv
// Shared types, codes and widths for the deque with search.
package dws_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OccW    = 5;

  typedef enum logic [ModeW-1:0] {
    ModePushFront = 3'd0,
    ModePushBack  = 3'd1,
    ModePopFront  = 3'd2,
    ModePopBack   = 3'd3,
    ModeSearch    = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle   = 4'b0001,
    SRead   = 4'b0010,
    SSearch = 4'b0100,
    SResp   = 4'b1000
  } state_e;

  // Entry store access request for one cycle.
  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

endpackage

// File: hdl/dws_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface dws_in_if;
  import dws_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dws_out_if;
  import dws_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    position;
  logic [ValueW-1:0]  removed_value;
  logic [OccW-1:0]    occupancy;

  modport source (output valid, output status, output position, output removed_value,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input position, input removed_value,
                  input occupancy, output ready);
endinterface

// File: hdl/dws_store.sv
// Ring-addressed entry store: front + offset wrap, one write or read port.
module dws_store #(
  parameter int unsigned DEPTH = dws_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  dws_pkg::store_ctl_t         ctl_i,
  input  logic [$clog2(DEPTH)-1:0]    front_i,
  input  logic [$clog2(DEPTH+1)-1:0]  offset_i,
  input  logic [dws_pkg::ValueW-1:0]  wdata_i,
  output logic [dws_pkg::ValueW-1:0]  rdata_o
);
  import dws_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DepthW = (CW+1)'(DEPTH);

  logic [CW:0]       sum;
  logic [CW:0]       wrapped;
  logic [AW-1:0]     addr;
  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rdata_q;

  // front < DEPTH and offset <= DEPTH, so one conditional subtract wraps
  assign sum     = (CW+1)'(front_i) + (CW+1)'(offset_i);
  assign wrapped = (sum >= DepthW) ? (sum - DepthW) : sum;
  assign addr    = wrapped[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/deque_with_search_unit.sv
// Top level of the bounded double-ended queue with linear search.
//
// Bounded deque of DEPTH signed 32-bit entries kept as a ring in a single-port
// memory. Each request transfer carries a mode (push front, push back, pop
// front, pop back, search) and a value; each produces exactly one result
// transfer with status, match position, popped value and the occupancy after
// the operation. Requests are taken one at a time: a push, a rejected pop,
// a search on an empty queue or an unused mode is ready for the result
// register in the cycle after the request transfer, a successful pop after
// one registered memory read, and a search once the scan hits or, on a miss,
// has compared the last held entry, since the search walks the ring through
// the one memory read port and a single 32-bit comparator, one entry per
// cycle. The request side is ready again once the result is loaded into the
// output register. The result sits in an output register, so a new request
// is taken while an earlier result still waits for its transfer. The store
// needs no clearing after reset; only held entries are ever read.
module deque_with_search_unit #(
  parameter int unsigned DEPTH = dws_pkg::DepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dws_in_if.sink     in_i,
  dws_out_if.source  out_o
);
  import dws_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [AW-1:0] IdxLast = AW'(DEPTH - 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     front_q, front_d;
  logic [AW-1:0]     cmp_q, cmp_d;
  logic [ValueW-1:0] key_q, key_d;

  // pending result
  status_e           res_status_q, res_status_d;
  logic [PosW-1:0]   res_pos_q, res_pos_d;
  logic [ValueW-1:0] res_rem_q, res_rem_d;
  logic [OccW-1:0]   res_occ_q, res_occ_d;

  // output register
  logic              out_vld_q, out_vld_d;
  status_e           out_status_q;
  logic [PosW-1:0]   out_pos_q;
  logic [ValueW-1:0] out_rem_q;
  logic [OccW-1:0]   out_occ_q;
  logic              out_ld;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  store_ctl_t        st_ctl;
  logic [CW-1:0]     st_offset;
  logic [ValueW-1:0] st_rdata;

  assign in_i.ready = (state_q == SIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (cnt_q == CntFull);
  assign is_empty   = (cnt_q == '0);
  assign front_dec  = (front_q == '0) ? IdxLast : (front_q - AW'(1));
  assign front_inc  = (front_q == IdxLast) ? '0 : (front_q + AW'(1));

  // Sequencer: pushes finish at the request, pops wait one memory read,
  // search walks entries through the shared read port and comparator.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    front_d      = front_q;
    cmp_d        = cmp_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_rem_d    = res_rem_q;
    res_occ_d    = res_occ_q;
    st_ctl       = '0;
    st_offset    = '0;
    out_ld       = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          key_d        = in_i.value;
          res_status_d = StOk;
          res_pos_d    = '0;
          res_rem_d    = '0;
          state_d      = SResp;
          unique case (in_i.mode)
            ModePushFront: begin
              if (is_full) begin
                res_status_d = StFull;
              end else begin
                // new front is the slot just before the old one
                st_ctl.wr = 1'b1;
                st_offset = CW'(DEPTH - 1);
                front_d   = front_dec;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            ModePushBack: begin
              if (is_full) begin
                res_status_d = StFull;
              end else begin
                st_ctl.wr = 1'b1;
                st_offset = cnt_q;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            ModePopFront: begin
              if (is_empty) begin
                res_status_d = StEmpty;
              end else begin
                st_ctl.rd = 1'b1;
                st_offset = '0;
                front_d   = front_inc;
                cnt_d     = cnt_q - CW'(1);
                state_d   = SRead;
              end
            end
            ModePopBack: begin
              if (is_empty) begin
                res_status_d = StEmpty;
              end else begin
                st_ctl.rd = 1'b1;
                st_offset = cnt_q - CW'(1);
                cnt_d     = cnt_q - CW'(1);
                state_d   = SRead;
              end
            end
            ModeSearch: begin
              if (is_empty) begin
                res_status_d = StNotFound;
              end else begin
                // fetch the front entry, compare it next cycle
                st_ctl.rd = 1'b1;
                st_offset = '0;
                cmp_d     = '0;
                state_d   = SSearch;
              end
            end
            default: begin
              // unused code: no state change, plain ok
            end
          endcase
          res_occ_d = OccW'(cnt_d);
        end
      end
      SRead: begin
        res_rem_d = st_rdata;
        state_d   = SResp;
      end
      SSearch: begin
        // st_rdata holds the entry at position cmp_q
        if (st_rdata == key_q) begin
          res_status_d = StOk;
          res_pos_d    = PosW'(cmp_q);
          state_d      = SResp;
        end else if (CW'(cmp_q) == (cnt_q - CW'(1))) begin
          res_status_d = StNotFound;
          state_d      = SResp;
        end else begin
          st_ctl.rd = 1'b1;
          st_offset = CW'(cmp_q) + CW'(1);
          cmp_d     = cmp_q + AW'(1);
        end
      end
      SResp: begin
        if (!out_vld_q || out_o.ready) begin
          out_ld  = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      front_q   <= '0;
      cmp_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      front_q   <= front_d;
      cmp_q     <= cmp_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_rem_q    <= res_rem_d;
    res_occ_q    <= res_occ_d;
    if (out_ld) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_rem_q    <= res_rem_q;
      out_occ_q    <= res_occ_q;
    end
  end

  dws_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .ctl_i    (st_ctl),
    .front_i  (front_q),
    .offset_i (st_offset),
    .wdata_i  (in_i.value),
    .rdata_o  (st_rdata)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = out_status_q;
  assign out_o.position      = out_pos_q;
  assign out_o.removed_value = out_rem_q;
  assign out_o.occupancy     = out_occ_q;

  // Occupancy never passes capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count above capacity");

  // A push on a full queue leaves the ring untouched.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full &&
     (in_i.mode == ModePushFront || in_i.mode == ModePushBack))
    |=> (cnt_q == $past(cnt_q)) && (front_q == $past(front_q)))
    else $error("push on full queue changed state");

  // The search scan stays inside the held entries.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSearch) |-> (CW'(cmp_q) < cnt_q))
    else $error("search scan past last held entry");

  // A pop on an empty queue leaves the ring untouched.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_empty &&
     (in_i.mode == ModePopFront || in_i.mode == ModePopBack))
    |=> (cnt_q == '0) && (front_q == $past(front_q)))
    else $error("pop on empty queue changed state");

endmodule
